// ===== hdl/otl_pkg.sv =====
// Shared types, character codes and helper functions for the token lexer.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package otl_pkg;

  // Datapath widths and queue sizing.
  localparam int VALUE_WIDTH = 32;
  localparam int LINE_WIDTH = 16;
  localparam int MAX_BURST = 3;
  localparam int BURST_CNT_W = $clog2(MAX_BURST + 1);
  localparam int QUEUE_DEPTH = 8;
  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = PTR_W + 1;

  // Character codes the lexer recognizes.
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_VTAB = 8'h0B;
  localparam logic [7:0] CH_FFEED = 8'h0C;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_UPPER_X = 8'h58;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_LOWER_X = 8'h78;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // Token kinds carried on the result channel.
  typedef enum logic [3:0] {
    KIND_EOF         = 4'd0,
    KIND_COMMA       = 4'd1,
    KIND_INTEGER     = 4'd2,
    KIND_LBRACE      = 4'd3,
    KIND_NAME_END    = 4'd4,
    KIND_RBRACE      = 4'd5,
    KIND_STRING_END  = 4'd6,
    KIND_JUNK        = 4'd7,
    KIND_NAME_CHAR   = 4'd8,
    KIND_STRING_CHAR = 4'd9,
    KIND_ERROR       = 4'd10
  } kind_t;

  // Error codes.
  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_SYNTAX = 2'd1,
    ERR_HEX    = 2'd2
  } err_t;

  // One result token.
  typedef struct packed {
    kind_t                  kind;
    logic [VALUE_WIDTH-1:0] value;
    err_t                   err;
    logic [LINE_WIDTH-1:0]  line;
    logic                   last;
  } token_t;

  // All results caused by one input byte.
  typedef struct packed {
    logic [BURST_CNT_W-1:0]      count;
    token_t [MAX_BURST-1:0]      tok;
  } burst_t;

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_octal(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_SEVEN);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_FFEED) || (c == CH_NEWLINE) ||
           (c == CH_CR) || (c == CH_TAB) || (c == CH_VTAB);
  endfunction

  // Hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] hv;
    hv = 5'd0;
    if (is_digit(c)) begin
      hv = {1'b1, c[3:0]};
    end else if (((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46))) begin
      hv = {1'b1, c[3:0] + 4'd9};
    end
    return hv;
  endfunction

  function automatic token_t make_token(input kind_t kind,
                                        input logic [VALUE_WIDTH-1:0] value,
                                        input err_t err,
                                        input logic [LINE_WIDTH-1:0] line);
    token_t t;
    t.kind = kind;
    t.value = value;
    t.err = err;
    t.line = line;
    t.last = 1'b0;
    return t;
  endfunction

endpackage

// ===== hdl/otl_lex_core.sv =====
// Lexer state registers and the combinational next-state and result logic.
// Depends on otl_pkg for token types, character codes and widths.
`timescale 1ns / 1ps

module otl_lex_core
  import otl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] text_byte,
  input  logic       end_of_input,
  output burst_t     burst
);

  typedef enum logic [3:0] {
    M_IDLE, M_COMMENT, M_NAME, M_STRING, M_ESCAPE, M_OCTAL, M_ZERO, M_DECIMAL, M_HEX
  } mode_t;

  mode_t                  mode_r, mode_nxt;
  logic [VALUE_WIDTH-1:0] acc_r, acc_nxt;
  logic [8:0]             oct_r, oct_nxt;
  logic [1:0]             ocnt_r, ocnt_nxt;
  logic                   seen_r, seen_nxt;
  logic [LINE_WIDTH-1:0]  line_r, line_nxt;
  logic                   halted_r, halted_nxt;

  logic                   again;
  logic                   idle_go;
  logic                   eoi;
  logic [7:0]             c;
  logic [4:0]             hv;
  logic [BURST_CNT_W-1:0] n;

  assign eoi = end_of_input;
  assign c = text_byte;
  assign hv = hex_value(text_byte);

  // One request worth of lexing: close any pending token, then handle the byte
  // in the mode that follows. Results are collected in order into the burst.
  always_comb begin
    mode_nxt = mode_r;
    acc_nxt = acc_r;
    oct_nxt = oct_r;
    ocnt_nxt = ocnt_r;
    seen_nxt = seen_r;
    line_nxt = line_r;
    halted_nxt = halted_r;
    again = 1'b0;
    idle_go = 1'b0;
    n = '0;
    burst = '0;

    if (!halted_r) begin
      // First pass: modes that may hand the byte back after closing a token.
      case (mode_r)
        M_COMMENT: begin
          if (eoi) begin
            mode_nxt = M_IDLE;
            again = 1'b1;
          end else if (c == CH_NEWLINE) begin
            if (line_nxt != {LINE_WIDTH{1'b1}}) line_nxt = line_nxt + LINE_WIDTH'(1);
            mode_nxt = M_IDLE;
          end
        end
        M_NAME: begin
          if (!eoi && (is_letter(c) || is_digit(c))) begin
            burst.tok[n] = make_token(KIND_NAME_CHAR, VALUE_WIDTH'(c), ERR_NONE, line_nxt);
            n = n + BURST_CNT_W'(1);
          end else begin
            burst.tok[n] = make_token(KIND_NAME_END, '0, ERR_NONE, line_nxt);
            n = n + BURST_CNT_W'(1);
            mode_nxt = M_IDLE;
            again = 1'b1;
          end
        end
        M_OCTAL: begin
          if (!eoi && is_octal(c)) begin
            oct_nxt = {oct_r[5:0], c[2:0]};
            if (ocnt_r == 2'd2) begin
              burst.tok[n] = make_token(KIND_STRING_CHAR, VALUE_WIDTH'(oct_nxt[7:0]),
                                        ERR_NONE, line_nxt);
              n = n + BURST_CNT_W'(1);
              ocnt_nxt = 2'd0;
              mode_nxt = M_STRING;
            end else begin
              ocnt_nxt = ocnt_r + 2'd1;
            end
          end else begin
            burst.tok[n] = make_token(KIND_STRING_CHAR, VALUE_WIDTH'(oct_r[7:0]),
                                      ERR_NONE, line_nxt);
            n = n + BURST_CNT_W'(1);
            ocnt_nxt = 2'd0;
            mode_nxt = M_STRING;
            again = 1'b1;
          end
        end
        M_ZERO: begin
          acc_nxt = '0;
          if (!eoi && ((c == CH_LOWER_X) || (c == CH_UPPER_X))) begin
            seen_nxt = 1'b0;
            mode_nxt = M_HEX;
          end else if (!eoi && is_digit(c)) begin
            acc_nxt = VALUE_WIDTH'(c[3:0]);
            mode_nxt = M_DECIMAL;
          end else begin
            burst.tok[n] = make_token(KIND_INTEGER, '0, ERR_NONE, line_nxt);
            n = n + BURST_CNT_W'(1);
            mode_nxt = M_IDLE;
            again = 1'b1;
          end
        end
        M_DECIMAL: begin
          if (!eoi && is_digit(c)) begin
            acc_nxt = (acc_r << 3) + (acc_r << 1) + VALUE_WIDTH'(c[3:0]);
          end else begin
            burst.tok[n] = make_token(KIND_INTEGER, acc_r, ERR_NONE, line_nxt);
            n = n + BURST_CNT_W'(1);
            mode_nxt = M_IDLE;
            again = 1'b1;
          end
        end
        M_HEX: begin
          if (!eoi && hv[4]) begin
            acc_nxt = {acc_r[VALUE_WIDTH-5:0], hv[3:0]};
            seen_nxt = 1'b1;
          end else if (!seen_r) begin
            burst.tok[n] = make_token(KIND_ERROR, '0, ERR_HEX, line_nxt);
            n = n + BURST_CNT_W'(1);
            halted_nxt = 1'b1;
          end else begin
            burst.tok[n] = make_token(KIND_INTEGER, acc_r, ERR_NONE, line_nxt);
            n = n + BURST_CNT_W'(1);
            mode_nxt = M_IDLE;
            again = 1'b1;
          end
        end
        M_IDLE, M_STRING, M_ESCAPE: begin
          again = 1'b1;
        end
        default: begin
          mode_nxt = M_IDLE;
          again = 1'b1;
        end
      endcase

      // Second pass: string body and escape handling.
      if (again) begin
        if (mode_nxt == M_STRING) begin
          if (eoi) begin
            burst.tok[n] = make_token(KIND_STRING_END, '0, ERR_NONE, line_nxt);
            n = n + BURST_CNT_W'(1);
            mode_nxt = M_IDLE;
            idle_go = 1'b1;
          end else begin
            if ((c == CH_NEWLINE) && (line_nxt != {LINE_WIDTH{1'b1}})) begin
              line_nxt = line_nxt + LINE_WIDTH'(1);
            end
            if (c == CH_QUOTE) begin
              burst.tok[n] = make_token(KIND_STRING_END, '0, ERR_NONE, line_nxt);
              n = n + BURST_CNT_W'(1);
              mode_nxt = M_IDLE;
            end else if (c == CH_NEWLINE) begin
              burst.tok[n] = make_token(KIND_ERROR, '0, ERR_SYNTAX, line_nxt);
              n = n + BURST_CNT_W'(1);
              halted_nxt = 1'b1;
            end else if (c == CH_BACKSLASH) begin
              mode_nxt = M_ESCAPE;
            end else begin
              burst.tok[n] = make_token(KIND_STRING_CHAR, VALUE_WIDTH'(c), ERR_NONE, line_nxt);
              n = n + BURST_CNT_W'(1);
            end
          end
        end else if (mode_nxt == M_ESCAPE) begin
          if (!eoi && (c == CH_NEWLINE) && (line_nxt != {LINE_WIDTH{1'b1}})) begin
            line_nxt = line_nxt + LINE_WIDTH'(1);
          end
          if (eoi || (c == CH_NEWLINE) || (c == CH_CR)) begin
            burst.tok[n] = make_token(KIND_ERROR, '0, ERR_SYNTAX, line_nxt);
            n = n + BURST_CNT_W'(1);
            halted_nxt = 1'b1;
          end else if (is_octal(c)) begin
            oct_nxt = 9'(c[2:0]);
            ocnt_nxt = 2'd1;
            mode_nxt = M_OCTAL;
          end else begin
            burst.tok[n] = make_token(KIND_STRING_CHAR, VALUE_WIDTH'(c), ERR_NONE, line_nxt);
            n = n + BURST_CNT_W'(1);
            mode_nxt = M_STRING;
          end
        end else begin
          idle_go = 1'b1;
        end
      end

      // Third pass: the byte starts something new from the idle mode.
      if (idle_go) begin
        mode_nxt = M_IDLE;
        if (eoi) begin
          burst.tok[n] = make_token(KIND_EOF, '0, ERR_NONE, line_nxt);
          n = n + BURST_CNT_W'(1);
        end else begin
          if ((c == CH_NEWLINE) && (line_nxt != {LINE_WIDTH{1'b1}})) begin
            line_nxt = line_nxt + LINE_WIDTH'(1);
          end
          if (is_space(c)) begin
            mode_nxt = M_IDLE;
          end else if (c == CH_HASH) begin
            mode_nxt = M_COMMENT;
          end else if (c == CH_COMMA) begin
            burst.tok[n] = make_token(KIND_COMMA, '0, ERR_NONE, line_nxt);
            n = n + BURST_CNT_W'(1);
          end else if (c == CH_LBRACE) begin
            burst.tok[n] = make_token(KIND_LBRACE, '0, ERR_NONE, line_nxt);
            n = n + BURST_CNT_W'(1);
          end else if (c == CH_RBRACE) begin
            burst.tok[n] = make_token(KIND_RBRACE, '0, ERR_NONE, line_nxt);
            n = n + BURST_CNT_W'(1);
          end else if (is_letter(c)) begin
            burst.tok[n] = make_token(KIND_NAME_CHAR, VALUE_WIDTH'(c), ERR_NONE, line_nxt);
            n = n + BURST_CNT_W'(1);
            mode_nxt = M_NAME;
          end else if (c == CH_QUOTE) begin
            mode_nxt = M_STRING;
          end else if (c == CH_ZERO) begin
            mode_nxt = M_ZERO;
          end else if (is_digit(c)) begin
            acc_nxt = VALUE_WIDTH'(c[3:0]);
            mode_nxt = M_DECIMAL;
          end else begin
            burst.tok[n] = make_token(KIND_JUNK, VALUE_WIDTH'(c), ERR_NONE, line_nxt);
            n = n + BURST_CNT_W'(1);
          end
        end
      end
    end

    // Mark the final result of the burst.
    burst.count = n;
    for (int k = 0; k < MAX_BURST; k++) begin
      burst.tok[k].last = (BURST_CNT_W'(k + 1) == n);
    end
  end

  // Lexer state advances once per accepted request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      acc_r <= '0;
      oct_r <= '0;
      ocnt_r <= '0;
      seen_r <= 1'b0;
      line_r <= LINE_WIDTH'(1);
      halted_r <= 1'b0;
    end else if (take) begin
      mode_r <= mode_nxt;
      acc_r <= acc_nxt;
      oct_r <= oct_nxt;
      ocnt_r <= ocnt_nxt;
      seen_r <= seen_nxt;
      line_r <= line_nxt;
      halted_r <= halted_nxt;
    end
  end

endmodule

// ===== hdl/otl_result_queue.sv =====
// Result queue: takes a burst of up to three tokens per cycle, drains one.
// Depends on otl_pkg for token_t, burst_t and the queue sizing constants.
`timescale 1ns / 1ps

module otl_result_queue
  import otl_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  burst_t burst,
  input  logic   pop,
  output token_t head,
  output logic   head_valid,
  output logic   room
);

  token_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  count_r, count_nxt;
  logic [QCNT_W-1:0]  push_cnt;

  // Pointer and fill count updates.
  always_comb begin
    push_cnt = push ? QCNT_W'(burst.count) : '0;
    wr_ptr_nxt = wr_ptr_r + PTR_W'(push_cnt);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
    count_nxt = count_r + push_cnt - QCNT_W'(pop);
  end

  assign head = mem_r[rd_ptr_r];
  assign head_valid = (count_r != '0);
  assign room = (count_r <= QCNT_W'(QUEUE_DEPTH - MAX_BURST));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  // Token storage: each burst entry lands in consecutive slots.
  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_BURST; k++) begin
      if (push && (BURST_CNT_W'(k) < burst.count)) begin
        mem_r[wr_ptr_r + PTR_W'(k)] <= burst.tok[k];
      end
    end
  end

endmodule

// ===== hdl/opcode_table_token_lexer.sv =====
// Top level of the streaming token lexer: lexer core plus result queue.
// Depends on otl_pkg, otl_lex_core and otl_result_queue.
`timescale 1ns / 1ps

// Usage:
//   The input channel (in_valid / in_stall) carries one text byte per request,
//   or an end-of-input mark when in_end_of_input is set. Each request yields
//   zero to three result tokens on the output channel (out_valid / out_stall);
//   out_last_result flags the final token caused by that request.
//   With an empty queue, the first token of a request is visible on the output
//   in the cycle after the request is accepted; further tokens follow one per
//   cycle unless stalled. Throughput: one byte per cycle while the receiver
//   keeps up and bytes average at most one token each. The lexer state updates
//   once per accepted byte; unless stalled, the queue drains one token per
//   cycle, so a byte that ends a token and starts another gives a short burst.
//   The queue holds eight tokens; in_stall rises while more than five are
//   waiting, which only depends on registered queue occupancy.
//   When the receiver stalls, the head token holds steady and the queue fills
//   until in_stall is raised. After a syntax or hex error the lexer halts:
//   requests are still accepted but give no tokens until reset.
//   Reset (synchronous, active low) returns the lexer to idle, line 1, and
//   empties the queue.
module opcode_table_token_lexer
  import otl_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_text_byte,
  input  logic                          in_end_of_input,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [3:0]                    out_token_kind,
  output logic signed [VALUE_WIDTH-1:0] out_token_value,
  output logic [1:0]                    out_error_code,
  output logic [LINE_WIDTH-1:0]         out_line_number,
  output logic                          out_last_result
);

  logic   take;
  logic   room;
  logic   pop;
  burst_t burst;
  token_t head;

  // Input handshake.
  assign in_stall = !room;
  assign take = in_valid && room;
  assign pop = out_valid && !out_stall;

  otl_lex_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (take),
    .text_byte    (in_text_byte),
    .end_of_input (in_end_of_input),
    .burst        (burst)
  );

  otl_result_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (take),
    .burst      (burst),
    .pop        (pop),
    .head       (head),
    .head_valid (out_valid),
    .room       (room)
  );

  // Output fields from the queue head.
  assign out_token_kind = head.kind;
  assign out_token_value = $signed(head.value);
  assign out_error_code = head.err;
  assign out_line_number = head.line;
  assign out_last_result = head.last;

endmodule

// ===== hdl/otl_checker.sv =====
// Port-level checker for the token lexer, bound to the top level.
// Depends on otl_pkg for token kinds, error codes and widths.
`timescale 1ns / 1ps

module otl_checker
  import otl_pkg::*;
(
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [7:0]                    in_text_byte,
  input logic                          in_end_of_input,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [3:0]                    out_token_kind,
  input logic signed [VALUE_WIDTH-1:0] out_token_value,
  input logic [1:0]                    out_error_code,
  input logic [LINE_WIDTH-1:0]         out_line_number,
  input logic                          out_last_result
);

  // A stalled result stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_token_kind) &&
    $stable(out_token_value) && $stable(out_line_number) && $stable(out_last_result))
    else $error("stalled result changed");

  // Error code is set exactly on error tokens.
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_token_kind == KIND_ERROR) == (out_error_code != ERR_NONE)))
    else $error("error code does not match token kind");

  // Error and end-of-file tokens always close their request's burst.
  a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_token_kind == KIND_ERROR) || (out_token_kind == KIND_EOF))
    |-> out_last_result)
    else $error("error or eof token not marked last");

  // Line numbers start at one and never go back to zero.
  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_line_number != '0))
    else $error("line number is zero");

endmodule

bind opcode_table_token_lexer otl_checker u_otl_checker (.*);

// ===== sim/tb_opcode_table_token_lexer.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the streaming token lexer: a scoreboard class
// predicts the tokens of each accepted request and checks every result.
// Depends on otl_pkg and the opcode_table_token_lexer RTL.

module tb_opcode_table_token_lexer;
  import otl_pkg::*;

  localparam int CYCLE_LIMIT = 20_000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_REQUESTS = 10;

  // Lexer modes of the prediction.
  typedef enum logic [3:0] {
    MODE_IDLE, MODE_COMMENT, MODE_NAME, MODE_STRING, MODE_ESCAPE,
    MODE_OCTAL, MODE_ZERO, MODE_DECIMAL, MODE_HEX
  } lex_mode_t;

  // Tracks lexer state, predicts tokens per request and checks the results.
  class token_scoreboard;
    lex_mode_t mode;
    logic [VALUE_WIDTH-1:0] number;
    logic [8:0] octal;
    logic [1:0] octal_digits;
    bit hex_digit_seen;
    logic [LINE_WIDTH-1:0] line_count;
    bit halted;
    token_t burst[$];
    token_t expected_tokens[$];
    int failures;

    function new();
      mode = MODE_IDLE;
      number = '0;
      octal = '0;
      octal_digits = '0;
      hex_digit_seen = 1'b0;
      line_count = 1;
      halted = 1'b0;
      failures = 0;
    endfunction

    function bit alpha(logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function bit decimal(logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
    endfunction

    function bit blank(logic [7:0] c);
      return c == CH_SPACE || c == CH_FFEED || c == CH_NEWLINE || c == CH_CR ||
             c == CH_TAB || c == CH_VTAB;
    endfunction

    function int hex_nibble(logic [7:0] c);
      if (decimal(c)) return int'(c) - 'h30;
      if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
      if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
      return -1;
    endfunction

    function void add_token(kind_t kind, logic [VALUE_WIDTH-1:0] value, err_t err);
      token_t t;
      if (burst.size() >= MAX_BURST) return;
      t.kind = kind;
      t.value = value;
      t.err = err;
      t.line = line_count;
      t.last = 1'b0;
      burst = {burst, t};
    endfunction

    function void halt_with(err_t err);
      add_token(KIND_ERROR, '0, err);
      halted = 1'b1;
    endfunction

    function void count_line(logic [7:0] c);
      if (c == CH_NEWLINE && line_count != '1) line_count++;
    endfunction

    // One pass of the lexer; returns 1 when the byte is handed back.
    function bit lex_byte(logic [7:0] c, bit eoi);
      int hv;
      hv = hex_nibble(c);
      case (mode)
        MODE_COMMENT: begin
          if (eoi) begin
            mode = MODE_IDLE;
            return 1'b1;
          end
          count_line(c);
          if (c == CH_NEWLINE) mode = MODE_IDLE;
          return 1'b0;
        end
        MODE_NAME: begin
          if (!eoi && (alpha(c) || decimal(c))) begin
            count_line(c);
            add_token(KIND_NAME_CHAR, c, ERR_NONE);
            return 1'b0;
          end
          add_token(KIND_NAME_END, '0, ERR_NONE);
          mode = MODE_IDLE;
          return 1'b1;
        end
        MODE_STRING: begin
          if (eoi) begin
            add_token(KIND_STRING_END, '0, ERR_NONE);
            mode = MODE_IDLE;
            return 1'b1;
          end
          count_line(c);
          if (c == CH_QUOTE) begin
            add_token(KIND_STRING_END, '0, ERR_NONE);
            mode = MODE_IDLE;
          end else if (c == CH_NEWLINE) begin
            halt_with(ERR_SYNTAX);
          end else if (c == CH_BACKSLASH) begin
            mode = MODE_ESCAPE;
          end else begin
            add_token(KIND_STRING_CHAR, c, ERR_NONE);
          end
          return 1'b0;
        end
        MODE_ESCAPE: begin
          if (eoi) begin
            halt_with(ERR_SYNTAX);
            return 1'b0;
          end
          count_line(c);
          if (c == CH_NEWLINE || c == CH_CR) begin
            halt_with(ERR_SYNTAX);
            return 1'b0;
          end
          if (c >= 8'h30 && c <= 8'h37) begin
            octal = {6'd0, c[2:0]};
            octal_digits = 2'd1;
            mode = MODE_OCTAL;
          end else begin
            add_token(KIND_STRING_CHAR, c, ERR_NONE);
            mode = MODE_STRING;
          end
          return 1'b0;
        end
        MODE_OCTAL: begin
          if (!eoi && c >= 8'h30 && c <= 8'h37) begin
            count_line(c);
            octal = {octal[5:0], c[2:0]};
            octal_digits++;
            if (octal_digits == 2'd3) begin
              add_token(KIND_STRING_CHAR, octal[7:0], ERR_NONE);
              octal_digits = '0;
              mode = MODE_STRING;
            end
            return 1'b0;
          end
          add_token(KIND_STRING_CHAR, octal[7:0], ERR_NONE);
          octal_digits = '0;
          mode = MODE_STRING;
          return 1'b1;
        end
        MODE_ZERO: begin
          number = '0;
          if (!eoi && (c == CH_LOWER_X || c == CH_UPPER_X)) begin
            count_line(c);
            hex_digit_seen = 1'b0;
            mode = MODE_HEX;
            return 1'b0;
          end
          mode = MODE_DECIMAL;
          return 1'b1;
        end
        MODE_DECIMAL: begin
          if (!eoi && decimal(c)) begin
            count_line(c);
            number = number * 10 + c[3:0];
            return 1'b0;
          end
          add_token(KIND_INTEGER, number, ERR_NONE);
          mode = MODE_IDLE;
          return 1'b1;
        end
        MODE_HEX: begin
          if (!eoi && hv >= 0) begin
            count_line(c);
            number = {number[VALUE_WIDTH-5:0], 4'(hv)};
            hex_digit_seen = 1'b1;
            return 1'b0;
          end
          if (!hex_digit_seen) begin
            halt_with(ERR_HEX);
            return 1'b0;
          end
          add_token(KIND_INTEGER, number, ERR_NONE);
          mode = MODE_IDLE;
          return 1'b1;
        end
        default: begin
          mode = MODE_IDLE;
          if (eoi) begin
            add_token(KIND_EOF, '0, ERR_NONE);
            return 1'b0;
          end
          count_line(c);
          if (blank(c)) return 1'b0;
          if (c == CH_HASH) begin
            mode = MODE_COMMENT;
          end else if (c == CH_COMMA) begin
            add_token(KIND_COMMA, '0, ERR_NONE);
          end else if (c == CH_LBRACE) begin
            add_token(KIND_LBRACE, '0, ERR_NONE);
          end else if (c == CH_RBRACE) begin
            add_token(KIND_RBRACE, '0, ERR_NONE);
          end else if (alpha(c)) begin
            add_token(KIND_NAME_CHAR, c, ERR_NONE);
            mode = MODE_NAME;
          end else if (c == CH_QUOTE) begin
            mode = MODE_STRING;
          end else if (c == CH_ZERO) begin
            mode = MODE_ZERO;
          end else if (decimal(c)) begin
            number = c[3:0];
            mode = MODE_DECIMAL;
          end else begin
            add_token(KIND_JUNK, c, ERR_NONE);
          end
          return 1'b0;
        end
      endcase
    endfunction

    // Runs one request through the lexer, leaving its tokens in burst.
    function void predict_tokens(logic [7:0] c, bit eoi);
      burst.delete();
      if (halted) return;
      for (int pass = 0; pass < 8; pass++) begin
        if (!lex_byte(c, eoi) || halted) break;
      end
      if (burst.size() != 0) burst[burst.size()-1].last = 1'b1;
    endfunction

    function void note_request(logic [7:0] c, bit eoi);
      predict_tokens(c, eoi);
      foreach (burst[i]) expected_tokens = {expected_tokens, burst[i]};
    endfunction

    // Tells whether a request would halt the lexer, leaving the state as is.
    function bit halts(logic [7:0] c, bit eoi);
      lex_mode_t saved_mode;
      logic [VALUE_WIDTH-1:0] saved_number;
      logic [8:0] saved_octal;
      logic [1:0] saved_digits;
      bit saved_hex;
      logic [LINE_WIDTH-1:0] saved_line;
      bit was_halted;
      bit result;
      saved_mode = mode;
      saved_number = number;
      saved_octal = octal;
      saved_digits = octal_digits;
      saved_hex = hex_digit_seen;
      saved_line = line_count;
      was_halted = halted;
      predict_tokens(c, eoi);
      result = halted && !was_halted;
      mode = saved_mode;
      number = saved_number;
      octal = saved_octal;
      octal_digits = saved_digits;
      hex_digit_seen = saved_hex;
      line_count = saved_line;
      halted = was_halted;
      burst.delete();
      return result;
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] got);
      failures++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
    endfunction

    function void check_result(logic [3:0] kind, logic [VALUE_WIDTH-1:0] value,
                               logic [1:0] err, logic [LINE_WIDTH-1:0] line_no,
                               logic last);
      token_t want;
      if (expected_tokens.size() == 0) begin
        failures++;
        $display("%0t: token mismatch: expected none, actual kind %0d value %0h",
                 $time, kind, value);
        return;
      end
      want = expected_tokens.pop_front();
      if (want.kind !== kind) report("token_kind", want.kind, kind);
      if (want.value !== value) report("token_value", want.value, value);
      if (want.err !== err) report("error_code", want.err, err);
      if (want.line !== line_no) report("line_number", want.line, line_no);
      if (want.last !== last) report("last_result", want.last, last);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_text_byte = 8'd0;
  logic in_end_of_input = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [3:0] out_token_kind;
  logic signed [VALUE_WIDTH-1:0] out_token_value;
  logic [1:0] out_error_code;
  logic [LINE_WIDTH-1:0] out_line_number;
  logic out_last_result;

  token_scoreboard sb;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int requests_sent = 0;
  int cycles = 0;
  logic holding = 1'b0;
  logic [7:0] separators [7] = '{CH_SPACE, CH_NEWLINE, CH_TAB, CH_CR, CH_COMMA,
                                 CH_FFEED, CH_VTAB};

  opcode_table_token_lexer u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_text_byte    (in_text_byte),
    .in_end_of_input (in_end_of_input),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_token_kind  (out_token_kind),
    .out_token_value (out_token_value),
    .out_error_code  (out_error_code),
    .out_line_number (out_line_number),
    .out_last_result (out_last_result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: random stalls, or a solid hold-off while one is running.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (holding) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Every accepted result is checked against the oldest expected token.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_token_kind, out_token_value, out_error_code,
                      out_line_number, out_last_result);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Offers one request, idling at random first, and waits for its acceptance.
  task automatic send_request(input logic [7:0] c, input bit eoi);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_text_byte <= c;
    in_end_of_input <= eoi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(c, eoi);
    requests_sent++;
  endtask

  // Same, but a request that would halt the lexer is replaced by an octal digit,
  // which every mode takes without an error.
  task automatic send_safe(input logic [7:0] c, input bit eoi);
    if (sb.halts(c, eoi)) send_request(8'h37, 1'b0);
    else send_request(c, eoi);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_request(s[i], 1'b0);
  endtask

  function automatic logic [7:0] pick_letter();
    return 8'($urandom_range(25)) + ($urandom_range(1) ? 8'h41 : 8'h61);
  endfunction

  function automatic logic [7:0] pick_digit();
    return 8'h30 + 8'($urandom_range(9));
  endfunction

  function automatic logic [7:0] pick_other(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    logic [7:0] r;
    do r = 8'($urandom_range(255)); while (r == a || r == b || r == c);
    return r;
  endfunction

  // One well-formed token with random content, or an end-of-input mark, then a separator.
  task automatic send_random_token();
    string hex_digits;
    logic [7:0] chars[$];
    logic [7:0] c;
    hex_digits = "0123456789abcdefABCDEF";
    case ($urandom_range(9))
      0: begin
        chars = {chars, pick_letter()};
        repeat ($urandom_range(6))
          chars = {chars, ($urandom_range(1) ? pick_letter() : pick_digit())};
      end
      1: begin
        chars = {chars, CH_QUOTE};
        repeat ($urandom_range(5)) begin
          case ($urandom_range(3))
            0: begin
              chars = {chars, CH_BACKSLASH};
              repeat ($urandom_range(1, 4)) chars = {chars, 8'h30 + 8'($urandom_range(7))};
            end
            1: begin
              chars = {chars, CH_BACKSLASH};
              chars = {chars, pick_other(CH_NEWLINE, CH_CR, CH_NEWLINE)};
            end
            default: chars = {chars, pick_other(CH_QUOTE, CH_BACKSLASH, CH_NEWLINE)};
          endcase
        end
        chars = {chars, CH_QUOTE};
      end
      2: begin
        chars = {chars, 8'h31 + 8'($urandom_range(8))};
        repeat ($urandom_range(11)) chars = {chars, pick_digit()};
      end
      3: begin
        chars = {chars, CH_ZERO};
        chars = {chars, ($urandom_range(1) ? CH_LOWER_X : CH_UPPER_X)};
        repeat ($urandom_range(1, 10)) chars = {chars, 8'(hex_digits[$urandom_range(21)])};
      end
      4: begin
        case ($urandom_range(2))
          0: chars = {chars, CH_COMMA};
          1: chars = {chars, CH_LBRACE};
          default: chars = {chars, CH_RBRACE};
        endcase
      end
      5: begin
        chars = {chars, CH_HASH};
        repeat ($urandom_range(6))
          chars = {chars, pick_other(CH_NEWLINE, CH_NEWLINE, CH_NEWLINE)};
        chars = {chars, CH_NEWLINE};
      end
      6: begin
        do c = 8'($urandom_range(255));
        while (sb.alpha(c) || sb.decimal(c) || sb.blank(c) ||
               c inside {CH_QUOTE, CH_HASH, CH_COMMA, CH_LBRACE, CH_RBRACE});
        chars = {chars, c};
      end
      7: begin
        chars = {chars, CH_ZERO};
        repeat ($urandom_range(3)) chars = {chars, pick_digit()};
      end
      8: begin
        send_safe(8'($urandom_range(255)), 1'b1);
      end
      default: begin
        chars = {chars, separators[$urandom_range(6)]};
      end
    endcase
    chars = {chars, separators[$urandom_range(6)]};
    foreach (chars[i]) send_safe(chars[i], 1'b0);
  endtask

  initial begin
    int phase_start;
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: an octal escape above 255 followed by a fourth digit.
    send_text("\"\\5771\"");
    // Leading zero read as decimal, braces, and the largest hex value.
    send_text("09{0xFFFFFFFF}");
    // Name ended by a brace, then a newline; top-bit junk byte.
    send_text("Z}\n");
    send_request(8'hFF, 1'b0);
    // End of input with an octal escape and a string still open.
    send_text("\"\\12");
    send_request(8'h5A, 1'b1);

    // Random phases with different idle and stall mixes.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 75;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 75;
        end
        default: begin
          send_idle_pct = 35;
          stall_pct = 35;
        end
      endcase
      phase_start = requests_sent;
      if (p == 0) begin
        // Long receiver hold-off while a long name keeps the queue filling.
        fork
          begin
            holding <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            holding <= 1'b0;
          end
        join_none
        send_safe(pick_letter(), 1'b0);
        repeat (40) send_safe(pick_letter(), 1'b0);
        send_safe(CH_SPACE, 1'b0);
      end
      while (requests_sent - phase_start < PHASE_REQUESTS) begin
        if ($urandom_range(99) < 80) send_random_token();
        else send_safe(8'($urandom_range(255)), $urandom_range(7) == 0);
      end
    end

    // Close whatever is pending so the lexer is idle again.
    while (sb.mode != MODE_IDLE) send_safe(8'($urandom_range(255)), 1'b1);

    // A short name and a comma, then end of input, with no idling.
    send_idle_pct = 0;
    stall_pct = 0;
    send_text("a,");
    send_request(8'hA5, 1'b1);

    // A single error at the end, since the lexer halts until reset.
    send_idle_pct = 35;
    stall_pct = 35;
    case ($urandom_range(5))
      0: send_text("\"a\n");
      1: begin
        send_text("\"\\");
        send_request(8'($urandom_range(255)), 1'b1);
      end
      2: send_text("\"\\\n");
      3: send_text("\"\\\r");
      4: send_text("0xg");
      default: begin
        send_text("0x");
        send_request(8'($urandom_range(255)), 1'b1);
      end
    endcase
    // Requests after the halt are accepted and give nothing.
    repeat (6) send_request(8'($urandom_range(255)), 1'($urandom_range(1)));
    in_valid <= 1'b0;

    while (sb.expected_tokens.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== opcode_table_token_lexer.f =====
hdl/otl_pkg.sv
hdl/otl_lex_core.sv
hdl/otl_result_queue.sv
hdl/opcode_table_token_lexer.sv
hdl/otl_checker.sv
sim/tb_opcode_table_token_lexer.sv
